// File: design/fpsa_pkg.sv
// fpsa_pkg: shared types, constants and status codes for the segment allocator
// no dependencies
package fpsa_pkg;

  localparam int MAX_SEGMENTS = 32;
  localparam int ADDR_BITS    = 20;
  localparam int IDX_W        = $clog2(MAX_SEGMENTS);
  localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);
  localparam int SIZE_W       = 21;
  localparam int START_W      = 20;
  localparam int REQ_W        = 21;
  localparam int HDR_W        = 7;
  localparam int REG_W        = 21;
  localparam int CFG_IDX_W    = 2;
  localparam int STATUS_W     = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_FIT_POLICY   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_BYTES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_BYTES = 2'd2;

  localparam logic [1:0] POL_FIRST = 2'd0;
  localparam logic [1:0] POL_BEST  = 2'd1;
  localparam logic [1:0] POL_WORST = 2'd2;
  localparam logic [1:0] POL_NEXT  = 2'd3;

  localparam logic [STATUS_W-1:0] ST_ALLOC   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FREED   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOSPACE = 3'd2;
  localparam logic [STATUS_W-1:0] ST_UNKNOWN = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd4;

  // one table entry
  typedef struct packed {
    logic [START_W-1:0] start;
    logic [SIZE_W-1:0]  size;
    logic               free;
  } seg_t;

  // row-wide shift command broadcast to every cell
  typedef struct packed {
    logic             ins_en;   // open a gap after ins_at
    logic [IDX_W-1:0] ins_at;
    seg_t             ins_seg;  // new entry at ins_at+1
    logic             del_en;   // close entry del_at
    logic [IDX_W-1:0] del_at;
    logic             wr_en;    // overwrite entry wr_at
    logic [IDX_W-1:0] wr_at;
    seg_t             wr_seg;
    logic             init;     // reset layout
    seg_t             init_seg;
  } row_cmd_t;

endpackage

// File: design/fpsa_if.sv
// fpsa_if: valid/ready channel carrying a payload of parametric width
// depends on nothing
interface fpsa_if #(parameter int W = 1);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: design/fpsa_cell.sv
// fpsa_cell: one table entry; takes its neighbor's entry on insert or delete
// depends on fpsa_pkg
module fpsa_cell (
  input  logic                            clk,
  input  logic [fpsa_pkg::IDX_W-1:0]      my_idx,
  input  fpsa_pkg::row_cmd_t              cmd,
  input  fpsa_pkg::seg_t                  left_seg,
  input  fpsa_pkg::seg_t                  right_seg,
  output fpsa_pkg::seg_t                  seg
);

  fpsa_pkg::seg_t seg_r, seg_nxt;

  // pick own, neighbor or written value
  always_comb begin
    seg_nxt = seg_r;
    if (cmd.init) begin
      seg_nxt = (my_idx == '0) ? cmd.init_seg : '0;
    end else if (cmd.ins_en) begin
      if (my_idx == cmd.ins_at + 1'b1) seg_nxt = cmd.ins_seg;
      else if (my_idx > cmd.ins_at + 1'b1) seg_nxt = left_seg;
      if (cmd.wr_en && my_idx == cmd.wr_at) seg_nxt = cmd.wr_seg;
    end else if (cmd.del_en) begin
      if (my_idx >= cmd.del_at) seg_nxt = right_seg;
      if (cmd.wr_en && my_idx == cmd.wr_at) seg_nxt = cmd.wr_seg;
    end else if (cmd.wr_en && my_idx == cmd.wr_at) begin
      seg_nxt = cmd.wr_seg;
    end
  end

  always_ff @(posedge clk) begin
    seg_r <= seg_nxt;
  end

  assign seg = seg_r;

endmodule

// File: design/fpsa_ctrl.sv
// fpsa_ctrl: sequencer that scans the cell row one entry a cycle and issues edits
// depends on fpsa_pkg
module fpsa_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic                            req_mode,
  input  logic [fpsa_pkg::REQ_W-1:0]      req_size,
  input  logic [fpsa_pkg::START_W-1:0]    req_addr,
  input  logic [1:0]                      policy,
  input  logic [fpsa_pkg::HDR_W-1:0]      hdr,
  input  logic                            cfg_init,
  input  fpsa_pkg::seg_t                  init_seg,
  input  fpsa_pkg::seg_t                  rd_seg,
  output logic [fpsa_pkg::IDX_W-1:0]      rd_idx,
  output fpsa_pkg::row_cmd_t              cmd,
  output logic                            busy,
  output logic                            done,
  output logic [fpsa_pkg::STATUS_W-1:0]   res_status,
  output logic [fpsa_pkg::START_W-1:0]    res_addr
);

  localparam int IW = fpsa_pkg::IDX_W;
  localparam int CW = fpsa_pkg::CNT_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_GRANT = 3'd2;
  localparam logic [2:0] S_MRGR  = 3'd3;
  localparam logic [2:0] S_MRGL  = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]                     state_r, state_nxt;
  logic [CW-1:0]                  count_r, count_nxt;
  logic [IW-1:0]                  cursor_r, cursor_nxt;
  logic [CW-1:0]                  step_r, step_nxt;     // entries visited
  logic [IW-1:0]                  pos_r, pos_nxt;       // entry being read
  logic                           found_r, found_nxt;
  logic [IW-1:0]                  best_r, best_nxt;
  fpsa_pkg::seg_t                 bseg_r, bseg_nxt;
  logic                           mode_r;
  logic [fpsa_pkg::REQ_W-1:0]     size_r;
  logic [fpsa_pkg::START_W-1:0]   addr_r;
  logic [fpsa_pkg::STATUS_W-1:0]  status_r, status_nxt;
  logic [fpsa_pkg::START_W-1:0]   oaddr_r, oaddr_nxt;

  logic [fpsa_pkg::REQ_W:0]       req_plus_hdr;
  logic                           usable;
  logic                           better;
  logic                           hit;
  logic [IW-1:0]                  pos_inc;
  logic [CW-1:0]                  best_ext;
  logic [fpsa_pkg::SIZE_W:0]      merged;
  logic [fpsa_pkg::START_W:0]     pay_addr;

  function automatic logic [fpsa_pkg::START_W-1:0] START_TRUNC(
    input logic [fpsa_pkg::REQ_W:0] v);
    START_TRUNC = v[fpsa_pkg::START_W-1:0];
  endfunction

  // cursor follows its segment when entry j leaves
  function automatic logic [IW-1:0] CURSOR_DEL(input logic [IW-1:0] c,
                                               input logic [IW-1:0] j,
                                               input logic [CW-1:0] cnt);
    logic [IW-1:0] r;
    r = c;
    if (c > j) r = c - 1'b1;
    else if (c == j && j != '0) r = j - 1'b1;
    if (CW'(r) >= cnt) r = '0;
    CURSOR_DEL = r;
  endfunction

  assign req_plus_hdr = {1'b0, size_r} + {{(fpsa_pkg::REQ_W-fpsa_pkg::HDR_W+1){1'b0}}, hdr};
  assign usable = rd_seg.free && ((rd_seg.size == size_r) ||
                  ({1'b0, rd_seg.size} > req_plus_hdr));
  assign pay_addr = {1'b0, rd_seg.start} + {{(fpsa_pkg::START_W-fpsa_pkg::HDR_W+1){1'b0}}, hdr};
  assign hit = !rd_seg.free && (pay_addr == {1'b0, addr_r});
  assign better = (policy == fpsa_pkg::POL_BEST)  ? (rd_seg.size < bseg_r.size) :
                  (policy == fpsa_pkg::POL_WORST) ? (rd_seg.size > bseg_r.size) : 1'b0;
  assign pos_inc = ({1'b0, pos_r} + 1'b1 >= count_r) ? '0 : pos_r + 1'b1;
  assign best_ext = CW'(best_r);
  assign rd_idx = pos_r;
  assign merged = {1'b0, bseg_r.size} + {{(fpsa_pkg::SIZE_W-fpsa_pkg::HDR_W+1){1'b0}}, hdr}
                  + {1'b0, rd_seg.size};

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    cursor_nxt = cursor_r;
    step_nxt   = step_r;
    pos_nxt    = pos_r;
    found_nxt  = found_r;
    best_nxt   = best_r;
    bseg_nxt   = bseg_r;
    status_nxt = status_r;
    oaddr_nxt  = oaddr_r;
    cmd        = '0;
    cmd.init_seg = init_seg;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_SCAN;
          step_nxt  = '0;
          found_nxt = 1'b0;
          pos_nxt   = (!req_mode && policy == fpsa_pkg::POL_NEXT &&
                       {1'b0, cursor_r} < count_r) ? cursor_r : '0;
        end
      end
      S_SCAN: begin
        step_nxt = step_r + 1'b1;
        pos_nxt  = pos_inc;
        if (mode_r) begin
          // free: look for the allocated entry at this address
          if (hit) begin
            best_nxt = pos_r;
            bseg_nxt = rd_seg;
            bseg_nxt.free = 1'b1;
            cmd.wr_en  = 1'b1;
            cmd.wr_at  = pos_r;
            cmd.wr_seg = bseg_nxt;
            status_nxt = fpsa_pkg::ST_FREED;
            oaddr_nxt  = '0;
            pos_nxt    = pos_r + 1'b1;
            state_nxt  = S_MRGR;
            if ({1'b0, pos_r} + 1'b1 >= count_r) begin
              pos_nxt   = pos_r - 1'b1;
              state_nxt = (pos_r == '0) ? S_DONE : S_MRGL;
            end
          end else if (step_r + 1'b1 >= count_r) begin
            status_nxt = fpsa_pkg::ST_UNKNOWN;
            oaddr_nxt  = '0;
            state_nxt  = S_DONE;
          end
        end else begin
          if (usable && (!found_r || better)) begin
            found_nxt = 1'b1;
            best_nxt  = pos_r;
            bseg_nxt  = rd_seg;
          end
          if (size_r == '0) begin
            status_nxt = fpsa_pkg::ST_NOSPACE;
            oaddr_nxt  = '0;
            state_nxt  = S_DONE;
          end else if ((usable && (policy == fpsa_pkg::POL_FIRST ||
                        policy == fpsa_pkg::POL_NEXT)) || step_r + 1'b1 >= count_r) begin
            state_nxt = S_GRANT;
          end
        end
      end
      S_GRANT: begin
        state_nxt = S_DONE;
        oaddr_nxt = '0;
        if (!found_r) begin
          status_nxt = fpsa_pkg::ST_NOSPACE;
        end else if (bseg_r.size != size_r && count_r >= CW'(fpsa_pkg::MAX_SEGMENTS)) begin
          status_nxt = fpsa_pkg::ST_FULL;
        end else begin
          cmd.wr_en      = 1'b1;
          cmd.wr_at      = best_r;
          cmd.wr_seg     = bseg_r;
          cmd.wr_seg.free = 1'b0;
          if (bseg_r.size != size_r) begin
            cmd.wr_seg.size = size_r;
            cmd.ins_en  = 1'b1;
            cmd.ins_at  = best_r;
            cmd.ins_seg.start = START_TRUNC(req_plus_hdr + {2'b0, bseg_r.start});
            cmd.ins_seg.size  = fpsa_pkg::SIZE_W'({1'b0, bseg_r.size} - req_plus_hdr);
            cmd.ins_seg.free  = 1'b1;
            count_nxt = count_r + 1'b1;
          end
          cursor_nxt = (best_ext + 1'b1 < count_nxt) ? best_r + 1'b1 : '0;
          status_nxt = fpsa_pkg::ST_ALLOC;
          oaddr_nxt  = fpsa_pkg::START_W'(bseg_r.start + {{(fpsa_pkg::START_W-fpsa_pkg::HDR_W){1'b0}}, hdr});
        end
      end
      S_MRGR: begin
        // rd_seg is the right neighbor of best_r
        state_nxt = (best_r == '0) ? S_DONE : S_MRGL;
        if (rd_seg.free) begin
          bseg_nxt.size = fpsa_pkg::SIZE_W'(merged);
          cmd.wr_en  = 1'b1;
          cmd.wr_at  = best_r;
          cmd.wr_seg = bseg_nxt;
          cmd.del_en = 1'b1;
          cmd.del_at = best_r + 1'b1;
          count_nxt  = count_r - 1'b1;
          cursor_nxt = CURSOR_DEL(cursor_r, best_r + 1'b1, count_nxt);
        end
        pos_nxt = best_r - 1'b1;
      end
      S_MRGL: begin
        // rd_seg is the left neighbor of best_r
        state_nxt = S_DONE;
        if (rd_seg.free) begin
          bseg_nxt      = rd_seg;
          bseg_nxt.size = fpsa_pkg::SIZE_W'({1'b0, rd_seg.size} +
                          {{(fpsa_pkg::SIZE_W-fpsa_pkg::HDR_W+1){1'b0}}, hdr} + {1'b0, bseg_r.size});
          cmd.wr_en  = 1'b1;
          cmd.wr_at  = best_r - 1'b1;
          cmd.wr_seg = bseg_nxt;
          cmd.del_en = 1'b1;
          cmd.del_at = best_r;
          count_nxt  = count_r - 1'b1;
          cursor_nxt = CURSOR_DEL(cursor_r, best_r, count_nxt);
        end
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    if (cfg_init) begin
      cmd        = '0;
      cmd.init   = 1'b1;
      cmd.init_seg = init_seg;
      count_nxt  = CW'(1);
      cursor_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= CW'(1);
      cursor_r <= '0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      cursor_r <= cursor_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r   <= step_nxt;
    pos_r    <= pos_nxt;
    found_r  <= found_nxt;
    best_r   <= best_nxt;
    bseg_r   <= bseg_nxt;
    status_r <= status_nxt;
    oaddr_r  <= oaddr_nxt;
    if (start && state_r == S_IDLE) begin
      mode_r <= req_mode;
      size_r <= req_size;
      addr_r <= req_addr;
    end
  end

  assign busy       = (state_r != S_IDLE);
  assign done       = (state_r == S_DONE);
  assign res_status = status_r;
  assign res_addr   = oaddr_r;

endmodule

// File: design/fit_policy_segment_allocator_core.sv
// fit_policy_segment_allocator_core: top level, register bank, cell row and output stage
// depends on fpsa_pkg, fpsa_if, fpsa_cell, fpsa_ctrl
//
// Usage: requests arrive on in_ch (mode, request_size, block_address), results leave
// on out_ch (status, address), both valid/ready; a request is taken when valid and
// ready are high at a clock edge. cfg_we/cfg_idx/cfg_data write fit_policy (0),
// region_bytes (1) and header_bytes (2); any such write rebuilds the table as one
// free segment covering the region. Write only while idle.
// The table lives in a row of MAX_SEGMENTS cells; inserts and deletes shift every entry
// past the edit point one cell together. The sequencer reads one entry per cycle, so the
// time to a result is set by the entry-by-entry scan; one request is in flight at a
// time, so a new request is taken only once the last result has left the output register.
// Reset (synchronous, rst_n low) restores the default registers and a single free
// segment. The result sits in an output register; while the receiver stalls it
// holds, and the next request is accepted in the cycle after it has been taken.
module fit_policy_segment_allocator_core (
  input  logic                              clk,
  input  logic                              rst_n,
  fpsa_if.sink                              in_ch,
  fpsa_if.source                            out_ch,
  input  logic                              cfg_we,
  input  logic [fpsa_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [fpsa_pkg::REG_W-1:0]        cfg_data
);

  localparam int N = fpsa_pkg::MAX_SEGMENTS;

  logic [1:0]                  policy_r;
  logic [fpsa_pkg::REG_W-1:0]  region_r;
  logic [fpsa_pkg::HDR_W-1:0]  hdr_r;
  logic                        init_r;
  fpsa_pkg::seg_t              init_seg;
  logic [fpsa_pkg::REG_W-1:0]  region_sat;

  fpsa_pkg::row_cmd_t          cmd;
  fpsa_pkg::seg_t              segs [N];
  logic [fpsa_pkg::IDX_W-1:0]  rd_idx;
  logic                        busy, done, start;
  logic [fpsa_pkg::STATUS_W-1:0] res_status;
  logic [fpsa_pkg::START_W-1:0]  res_addr;
  logic                        ovalid_r;
  logic [fpsa_pkg::STATUS_W+fpsa_pkg::START_W-1:0] odata_r;

  // register bank; a write to a defined register arms a table rebuild
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r <= fpsa_pkg::POL_FIRST;
      region_r <= fpsa_pkg::REG_W'(1048576);
      hdr_r    <= fpsa_pkg::HDR_W'(24);
      init_r   <= 1'b1;
    end else begin
      init_r <= 1'b0;
      if (cfg_we) begin
        case (cfg_idx)
          fpsa_pkg::CFG_FIT_POLICY:   begin policy_r <= cfg_data[1:0]; init_r <= 1'b1; end
          fpsa_pkg::CFG_REGION_BYTES: begin region_r <= cfg_data; init_r <= 1'b1; end
          fpsa_pkg::CFG_HEADER_BYTES: begin
            hdr_r <= cfg_data[fpsa_pkg::HDR_W-1:0]; init_r <= 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  // initial segment
  always_comb begin
    region_sat = (region_r > (fpsa_pkg::REG_W'(1) << fpsa_pkg::ADDR_BITS)) ?
                 (fpsa_pkg::REG_W'(1) << fpsa_pkg::ADDR_BITS) : region_r;
    init_seg.start = '0;
    init_seg.size  = (region_sat > fpsa_pkg::REG_W'(hdr_r)) ?
                     fpsa_pkg::SIZE_W'(region_sat - fpsa_pkg::REG_W'(hdr_r)) : '0;
    init_seg.free  = 1'b1;
  end

  // cell row
  for (genvar g = 0; g < N; g++) begin : g_cell
    fpsa_cell u_cell (
      .clk       (clk),
      .my_idx    (fpsa_pkg::IDX_W'(g)),
      .cmd       (cmd),
      .left_seg  (segs[(g == 0) ? 0 : g - 1]),
      .right_seg (segs[(g == N - 1) ? N - 1 : g + 1]),
      .seg       (segs[g])
    );
  end

  assign start = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !busy && !init_r && !ovalid_r;

  fpsa_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .req_mode   (in_ch.data[0]),
    .req_size   (in_ch.data[fpsa_pkg::REQ_W:1]),
    .req_addr   (in_ch.data[fpsa_pkg::REQ_W+fpsa_pkg::START_W:fpsa_pkg::REQ_W+1]),
    .policy     (policy_r),
    .hdr        (hdr_r),
    .cfg_init   (init_r),
    .init_seg   (init_seg),
    .rd_seg     (segs[rd_idx]),
    .rd_idx     (rd_idx),
    .cmd        (cmd),
    .busy       (busy),
    .done       (done),
    .res_status (res_status),
    .res_addr   (res_addr)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else if (done) begin
      ovalid_r <= 1'b1;
    end else if (out_ch.ready) begin
      ovalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) odata_r <= {res_addr, res_status};
  end

  assign out_ch.valid = ovalid_r;
  assign out_ch.data  = odata_r;

endmodule
